FILE: src/ear_pkg.sv
// ----------------------------------------------------------------------------
// ear_pkg
// shared constants for the eye aspect ratio block
// ----------------------------------------------------------------------------
package ear_pkg;

    localparam int SQRT_FRAC_BITS = 8;
    localparam int RATIO_W        = 16;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 16'hFFFF;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_LVL_W    = 3;

endpackage

FILE: src/eye_aspect_ratio.sv
// ----------------------------------------------------------------------------
// eye_aspect_ratio
// six-landmark eye aspect ratio (v1+v2)/(2h), U.F result, saturating
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// command   in         start & !busy             x0..x5, y0..y5
// result    out        done, one cycle, no stall ratio, degenerate
//
// front: difference and square registers, then a 4-word queue
// back: COORD_BITS+9-bit serial square roots (three lanes in parallel), then a
//   bit-serial divide to a COORD_BITS+10+RATIO_FRAC_BITS-bit quotient after
//   a load from the queue head; degenerate words skip the divide
// sustained rate is set by the back end's serial root and divide
// busy rises when queue plus front stages hold four words
// reset clears control only; done is never held off by the receiver
// ----------------------------------------------------------------------------
module eye_aspect_ratio import ear_pkg::*; #(
    parameter int COORD_BITS      = 12,
    parameter int RATIO_FRAC_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COORD_BITS-1:0]   x0,
    input  logic [COORD_BITS-1:0]   y0,
    input  logic [COORD_BITS-1:0]   x1,
    input  logic [COORD_BITS-1:0]   y1,
    input  logic [COORD_BITS-1:0]   x2,
    input  logic [COORD_BITS-1:0]   y2,
    input  logic [COORD_BITS-1:0]   x3,
    input  logic [COORD_BITS-1:0]   y3,
    input  logic [COORD_BITS-1:0]   x4,
    input  logic [COORD_BITS-1:0]   y4,
    input  logic [COORD_BITS-1:0]   x5,
    input  logic [COORD_BITS-1:0]   y5,
    output logic                    done,
    output logic [RATIO_W-1:0]      ratio,
    output logic                    degenerate
);

    localparam int SQ_W = 2 * COORD_BITS + 1;
    localparam int QW   = 3 * SQ_W;

    logic                    accept;
    logic                    s1_valid, s2_valid;
    logic [SQ_W-1:0]         f_v1, f_v2, f_h;
    logic                    q_valid, q_pop;
    logic [QW-1:0]           q_head;
    logic [QUEUE_LVL_W-1:0]  q_level;
    logic [QUEUE_LVL_W:0]    in_flight;

    // words held or on the way into the queue
    assign in_flight = {1'b0, q_level} + {{QUEUE_LVL_W{1'b0}}, s1_valid}
                     + {{QUEUE_LVL_W{1'b0}}, s2_valid};
    assign busy   = (in_flight >= (QUEUE_LVL_W+1)'(QUEUE_DEPTH));
    assign accept = start && !busy;

    ear_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .x0 (x0), .y0 (y0), .x1 (x1), .y1 (y1), .x2 (x2), .y2 (y2),
        .x3 (x3), .y3 (y3), .x4 (x4), .y4 (y4), .x5 (x5), .y5 (y5),
        .s1_valid (s1_valid),
        .s2_valid (s2_valid),
        .sq_v1    (f_v1),
        .sq_v2    (f_v2),
        .sq_h     (f_h)
    );

    ear_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid),
        .push_data ({f_v1, f_v2, f_h}),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head),
        .level     (q_level)
    );

    ear_back #(
        .COORD_BITS      (COORD_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (q_valid),
        .sq_v1      (q_head[3*SQ_W-1 -: SQ_W]),
        .sq_v2      (q_head[2*SQ_W-1 -: SQ_W]),
        .sq_h       (q_head[SQ_W-1:0]),
        .pop        (q_pop),
        .done       (done),
        .ratio      (ratio),
        .degenerate (degenerate)
    );

endmodule

FILE: src/ear_front.sv
// ----------------------------------------------------------------------------
// ear_front
// two-stage front: coordinate differences, then squares and sums
// ----------------------------------------------------------------------------
module ear_front import ear_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [COORD_BITS-1:0]   x0, y0, x1, y1, x2, y2,
    input  logic [COORD_BITS-1:0]   x3, y3, x4, y4, x5, y5,
    output logic                    s1_valid,
    output logic                    s2_valid,
    output logic [2*COORD_BITS:0]   sq_v1,
    output logic [2*COORD_BITS:0]   sq_v2,
    output logic [2*COORD_BITS:0]   sq_h
);

    localparam int SW = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] d_reg [6];
    logic [SW-1:0]         p_reg [6];
    logic                  v1_reg, v2_reg;

    function automatic logic [COORD_BITS-1:0] absd(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg[0] <= absd(x1, x5);
            d_reg[1] <= absd(y1, y5);
            d_reg[2] <= absd(x2, x4);
            d_reg[3] <= absd(y2, y4);
            d_reg[4] <= absd(x0, x3);
            d_reg[5] <= absd(y0, y3);
        end
        if (v1_reg)
        begin
            for (int i = 0; i < 6; i++)
            begin
                p_reg[i] <= d_reg[i] * d_reg[i];
            end
        end
    end

    assign s1_valid = v1_reg;
    assign s2_valid = v2_reg;
    assign sq_v1 = {1'b0, p_reg[0]} + {1'b0, p_reg[1]};
    assign sq_v2 = {1'b0, p_reg[2]} + {1'b0, p_reg[3]};
    assign sq_h  = {1'b0, p_reg[4]} + {1'b0, p_reg[5]};

endmodule

FILE: src/ear_queue.sv
// ----------------------------------------------------------------------------
// ear_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module ear_queue import ear_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic                    not_empty,
    output logic [WIDTH-1:0]        head,
    output logic [QUEUE_LVL_W-1:0]  level
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]          wr_reg, rd_reg;
    logic [QUEUE_LVL_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
    assign level     = cnt_reg;

endmodule

FILE: src/ear_back.sv
// ----------------------------------------------------------------------------
// ear_back
// three bit-serial square roots, then a saturating serial divide if h != 0
// ----------------------------------------------------------------------------
module ear_back import ear_pkg::*; #(
    parameter int COORD_BITS      = 12,
    parameter int RATIO_FRAC_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    word_valid,
    input  logic [2*COORD_BITS:0]   sq_v1,
    input  logic [2*COORD_BITS:0]   sq_v2,
    input  logic [2*COORD_BITS:0]   sq_h,
    output logic                    pop,
    output logic                    done,
    output logic [RATIO_W-1:0]      ratio,
    output logic                    degenerate
);

    localparam int R     = COORD_BITS + 9;              // root width, U.8
    localparam int RAD_W = 2 * R;
    localparam int SQ_W  = 2 * COORD_BITS + 1;
    localparam int NUM_W = R + 1 + RATIO_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SQRT, ST_DIV} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [RAD_W-1:0]   rad_reg  [3];
    logic [R+1:0]       rem_reg  [3];
    logic [R-1:0]       root_reg [3];
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [R:0]         prem_reg;
    logic               degen_reg;
    logic               done_reg;
    logic [RATIO_W-1:0] ratio_reg;

    logic [R+1:0]       rem_t  [3];
    logic [R+1:0]       trial  [3];
    logic [R-1:0]       root_nx [3];
    logic [R+1:0]       div_t;
    logic [R+1:0]       den;
    logic               div_ge;
    logic [NUM_W-1:0]   quo_next;
    logic [RAD_W-1:0]   rad_in [3];

    always_comb
    begin
        rad_in[0] = {{(RAD_W-SQ_W-2*SQRT_FRAC_BITS){1'b0}}, sq_v1, {(2*SQRT_FRAC_BITS){1'b0}}};
        rad_in[1] = {{(RAD_W-SQ_W-2*SQRT_FRAC_BITS){1'b0}}, sq_v2, {(2*SQRT_FRAC_BITS){1'b0}}};
        rad_in[2] = {{(RAD_W-SQ_W-2*SQRT_FRAC_BITS){1'b0}}, sq_h, {(2*SQRT_FRAC_BITS){1'b0}}};
        for (int i = 0; i < 3; i++)
        begin
            rem_t[i]   = {rem_reg[i][R-1:0], rad_reg[i][RAD_W-1 -: 2]};
            trial[i]   = {root_reg[i], 2'b01};
            root_nx[i] = {root_reg[i][R-2:0], (rem_t[i] >= trial[i])};
        end
        den      = {1'b0, root_reg[2], 1'b0};
        div_t    = {prem_reg, num_reg[NUM_W-1]};
        div_ge   = (div_t >= den);
        quo_next = {quo_reg[NUM_W-2:0], div_ge};
    end

    assign pop = (state_reg == ST_IDLE) && word_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (word_valid)
                    begin
                        state_reg <= ST_SQRT;
                        cnt_reg   <= CNT_W'(R);
                    end
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        if (degen_reg)
                        begin
                            state_reg <= ST_IDLE;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                            cnt_reg   <= CNT_W'(NUM_W);
                        end
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (word_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        rad_reg[i]  <= rad_in[i];
                        rem_reg[i]  <= '0;
                        root_reg[i] <= '0;
                    end
                    degen_reg <= (sq_h == '0);
                end
            end
            ST_SQRT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rad_reg[i] <= {rad_reg[i][RAD_W-3:0], 2'b00};
                    if (rem_t[i] >= trial[i])
                    begin
                        rem_reg[i]  <= rem_t[i] - trial[i];
                        root_reg[i] <= {root_reg[i][R-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i]  <= rem_t[i];
                        root_reg[i] <= {root_reg[i][R-2:0], 1'b0};
                    end
                end
                // numerator from the roots as they stand after this step
                num_reg  <= {({1'b0, root_nx[0]} + {1'b0, root_nx[1]}),
                             {RATIO_FRAC_BITS{1'b0}}};
                prem_reg <= '0;
                quo_reg  <= '0;
                if (cnt_reg == CNT_W'(1))
                begin
                    // ratio is zero for a degenerate word
                    ratio_reg <= '0;
                end
            end
            ST_DIV:
            begin
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                prem_reg <= div_ge ? (R+1)'(div_t - den) : div_t[R:0];
                quo_reg  <= quo_next;
                if (cnt_reg == CNT_W'(1))
                    ratio_reg <= (quo_next > NUM_W'(RATIO_MAX)) ? RATIO_MAX
                                                                 : quo_next[RATIO_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign done       = done_reg;
    assign ratio      = ratio_reg;
    assign degenerate = degen_reg;

endmodule
